// ----- rtl/frw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_pkg
// Types and constants shared by the flash record ring wear leveler.
// ----------------------------------------------------------------------------
package frw_pkg;

   localparam int unsigned ADDR_W = 24;

   localparam logic [1:0] REQ_WRITE     = 2'd0;
   localparam logic [1:0] REQ_SCAN_INIT = 2'd1;
   localparam logic [1:0] REQ_SCAN_READ = 2'd2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_SCAN  = 1'b1;

   localparam logic [15:0]       HEADER_MAGIC = 16'hA55A;
   localparam logic [ADDR_W-1:0] BASE_RESET   = 24'h010000;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        header_read_error;
      logic [15:0] header_magic;
      logic [31:0] header_sequence;
      logic [15:0] header_checksum;
      logic [31:0] payload_seconds;
      logic [31:0] payload_word_a;
      logic [15:0] payload_half_b;
   } frw_req_item_type;

   typedef struct packed {
      logic              result_kind;
      logic [ADDR_W-1:0] slot_address;
      logic              erase_first;
      logic [31:0]       record_sequence;
      logic [15:0]       record_checksum;
      logic              found_valid;
      logic [3:0]        found_slot;
      logic [3:0]        next_write_slot;
      logic [31:0]       found_seconds;
      logic [31:0]       found_word_a;
      logic [15:0]       found_half_b;
   } frw_rsp_item_type;

   typedef struct packed {
      logic             valid;
      frw_req_item_type item;
   } frw_stage_type;

endpackage

// ----- rtl/frw_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_req_if
// Request channel: valid, ready and one request item.
// ----------------------------------------------------------------------------
interface frw_req_if import frw_pkg::*; ();
   logic             valid;
   logic             ready;
   frw_req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/frw_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_rsp_if
// Response channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface frw_rsp_if import frw_pkg::*; ();
   logic             valid;
   logic             ready;
   frw_rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/flash_record_ring_wear_leveler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_record_ring_wear_leveler
// Round-robin record ring for flash: write commands and newest-record scans.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                      Carries
//  req_bus   in         valid, ready, payload      write request or slot header
//  rsp_bus   out        valid, ready, payload      write command or scan outcome
//  csr_*     in         csr_we, csr_wdata          ring base address
//
//  An item is registered at the input and, once the output register is free,
//  processed into it; writes and closing scan headers leave a result there.
//  While the output register is free, one item per cycle is sustained; only
//  it throttles input. A stalled result holds while the input register still
//  takes one more item. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module flash_record_ring_wear_leveler import frw_pkg::*; #(
   parameter int unsigned SLOT_COUNT        = 16,
   parameter int unsigned SLOT_STRIDE_BYTES = 1024,
   parameter int unsigned SECTOR_BYTES      = 4096
) (
   input  logic              clock,
   input  logic              reset,
   frw_req_if.sink           req_bus,
   frw_rsp_if.source         rsp_bus,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_wdata
);

   frw_stage_type    stage;
   logic             out_free;
   logic             fire;
   logic             has_result;
   frw_rsp_item_type result;
   logic             rsp_valid_ff, rsp_valid_in;
   frw_rsp_item_type rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fire     = stage.valid && out_free;

   frw_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .advance (out_free),
      .stage   (stage)
   );

   frw_core #(
      .SLOT_COUNT        (SLOT_COUNT),
      .SLOT_STRIDE_BYTES (SLOT_STRIDE_BYTES),
      .SECTOR_BYTES      (SECTOR_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .stage      (stage),
      .fire       (fire),
      .has_result (has_result),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

endmodule

// ----- rtl/frw_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_in_stage
// Input register that holds one request item until the core takes it.
// ----------------------------------------------------------------------------
module frw_in_stage import frw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   frw_req_if.sink       req_bus,
   input  logic          advance,
   output frw_stage_type stage
);

   logic             valid_ff;
   logic             valid_in;
   frw_req_item_type item_ff;
   logic             take;

   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_bus.payload;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// ----- rtl/frw_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_core
// Slot ring state, header scan and write command generation.
// ----------------------------------------------------------------------------
module frw_core import frw_pkg::*; #(
   parameter int unsigned SLOT_COUNT        = 16,
   parameter int unsigned SLOT_STRIDE_BYTES = 1024,
   parameter int unsigned SECTOR_BYTES      = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_wdata,
   input  frw_stage_type     stage,
   input  logic              fire,
   output logic              has_result,
   output frw_rsp_item_type  result
);

   function automatic int unsigned trailing_zeros(input int unsigned v);
      int unsigned w;
      int unsigned n;
      begin
         w = v;
         n = 0;
         for (int i = 0; i < 24; i++) begin
            if (w != 0 && (w & 1) == 0) begin
               w = w >> 1;
               n = n + 1;
            end
         end
         return n;
      end
   endfunction

   function automatic logic [ADDR_W-1:0] odd_inverse(input logic [ADDR_W-1:0] m);
      logic [ADDR_W-1:0] x;
      begin
         x = m;
         for (int i = 0; i < 5; i++) begin
            x = x * (24'd2 - m * x);
         end
         return x;
      end
   endfunction

   function automatic logic [15:0] payload_sum(input logic [31:0] secs,
                                               input logic [31:0] word_a,
                                               input logic [15:0] half_b);
      logic [11:0] acc;
      begin
         acc = 12'(half_b[7:0]) + 12'(half_b[15:8]);
         for (int i = 0; i < 4; i++) begin
            acc = acc + 12'(secs[8*i +: 8]) + 12'(word_a[8*i +: 8]);
         end
         return 16'(acc);
      end
   endfunction

   localparam int unsigned       SLOT_W     = $clog2(SLOT_COUNT);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [ADDR_W-1:0] STRIDE     = ADDR_W'(SLOT_STRIDE_BYTES);
   localparam int unsigned       SECTOR_TZ  = trailing_zeros(SECTOR_BYTES);
   localparam int unsigned       SECTOR_ODD = SECTOR_BYTES >> SECTOR_TZ;
   localparam logic [ADDR_W-1:0] TZ_MASK    = ADDR_W'((64'd1 << SECTOR_TZ) - 64'd1);
   localparam logic [ADDR_W-1:0] SECTOR_INV = odd_inverse(ADDR_W'(SECTOR_ODD));
   localparam logic [ADDR_W-1:0] DIV_LIMIT  = ADDR_W'(32'h00FF_FFFF / SECTOR_ODD);

   logic [ADDR_W-1:0] base_ff;
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic [ADDR_W-1:0] offset_ff, offset_in;
   logic [31:0]       wseq_ff, wseq_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] scan_off_ff, scan_off_in;
   logic              best_valid_ff, best_valid_in;
   logic [31:0]       best_seq_ff, best_seq_in;
   logic [SLOT_W-1:0] best_slot_ff, best_slot_in;
   logic [SLOT_W-1:0] best_nslot_ff, best_nslot_in;
   logic [ADDR_W-1:0] best_noff_ff, best_noff_in;
   logic [31:0]       best_secs_ff, best_secs_in;
   logic [31:0]       best_word_ff, best_word_in;
   logic [15:0]       best_half_ff, best_half_in;

   frw_req_item_type  it;
   logic              is_write;
   logic              is_scan;
   logic              slot_last;
   logic [SLOT_W-1:0] slot_next;
   logic [ADDR_W-1:0] offset_next;
   logic [ADDR_W-1:0] addr;
   logic [ADDR_W-1:0] addr_prod;
   logic              erase;
   logic [15:0]       sum;
   logic [31:0]       wseq_inc;
   logic              pos_first;
   logic              pos_last;
   logic [SLOT_W-1:0] pos_nslot;
   logic [ADDR_W-1:0] pos_noff;
   logic              cur_valid;
   logic [31:0]       cur_seq;
   logic              hit;
   logic [SLOT_W-1:0] reload_slot;
   logic [ADDR_W-1:0] reload_off;
   logic [31:0]       reload_seq;

   assign it          = stage.item;
   assign is_write    = it.req_type == REQ_WRITE;
   assign is_scan     = it.req_type == REQ_SCAN_INIT || it.req_type == REQ_SCAN_READ;
   assign slot_last   = next_slot_ff == SLOT_LAST;
   assign slot_next   = slot_last ? '0 : next_slot_ff + SLOT_W'(1);
   assign offset_next = slot_last ? '0 : offset_ff + STRIDE;
   assign addr        = base_ff + offset_ff;
   assign addr_prod   = addr * SECTOR_INV;
   assign erase       = (addr & TZ_MASK) == '0 && addr_prod <= DIV_LIMIT;
   assign sum         = payload_sum(it.payload_seconds, it.payload_word_a, it.payload_half_b);
   assign wseq_inc    = wseq_ff + 32'd1;

   assign pos_first = pos_ff == '0;
   assign pos_last  = pos_ff == SLOT_LAST;
   assign pos_nslot = pos_last ? '0 : pos_ff + SLOT_W'(1);
   assign pos_noff  = pos_last ? '0 : scan_off_ff + STRIDE;
   assign cur_valid = pos_first ? 1'b0 : best_valid_ff;
   assign cur_seq   = pos_first ? 32'd0 : best_seq_ff;
   assign hit       = !it.header_read_error && it.header_magic == HEADER_MAGIC &&
                      it.header_checksum == sum && it.header_sequence > cur_seq;

   always_comb begin
      best_valid_in = cur_valid;
      best_seq_in   = cur_seq;
      best_slot_in  = best_slot_ff;
      best_nslot_in = best_nslot_ff;
      best_noff_in  = best_noff_ff;
      best_secs_in  = best_secs_ff;
      best_word_in  = best_word_ff;
      best_half_in  = best_half_ff;
      if (hit) begin
         best_valid_in = 1'b1;
         best_seq_in   = it.header_sequence;
         best_slot_in  = pos_ff;
         best_nslot_in = pos_nslot;
         best_noff_in  = pos_noff;
         best_secs_in  = it.payload_seconds;
         best_word_in  = it.payload_word_a;
         best_half_in  = it.payload_half_b;
      end
      reload_slot = best_valid_in ? best_nslot_in : '0;
      reload_off  = best_valid_in ? best_noff_in : '0;
      reload_seq  = best_valid_in ? best_seq_in : 32'd0;
   end

   always_comb begin
      next_slot_in = next_slot_ff;
      offset_in    = offset_ff;
      wseq_in      = wseq_ff;
      pos_in       = pos_ff;
      scan_off_in  = scan_off_ff;
      if (fire && is_write) begin
         next_slot_in = slot_next;
         offset_in    = offset_next;
         wseq_in      = wseq_inc;
      end
      if (fire && is_scan) begin
         pos_in      = pos_nslot;
         scan_off_in = pos_noff;
         if (pos_last && it.req_type == REQ_SCAN_INIT) begin
            next_slot_in = reload_slot;
            offset_in    = reload_off;
            wseq_in      = reload_seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= BASE_RESET;
         next_slot_ff  <= '0;
         offset_ff     <= '0;
         wseq_ff       <= '0;
         pos_ff        <= '0;
         scan_off_ff   <= '0;
         best_valid_ff <= 1'b0;
         best_seq_ff   <= '0;
      end else begin
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         next_slot_ff <= next_slot_in;
         offset_ff    <= offset_in;
         wseq_ff      <= wseq_in;
         pos_ff       <= pos_in;
         scan_off_ff  <= scan_off_in;
         if (fire && is_scan) begin
            best_valid_ff <= best_valid_in;
            best_seq_ff   <= best_seq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_scan) begin
         best_slot_ff  <= best_slot_in;
         best_nslot_ff <= best_nslot_in;
         best_noff_ff  <= best_noff_in;
         best_secs_ff  <= best_secs_in;
         best_word_ff  <= best_word_in;
         best_half_ff  <= best_half_in;
      end
   end

   assign has_result = fire && (is_write || (is_scan && pos_last));

   always_comb begin
      result = '0;
      if (is_write) begin
         result.result_kind     = KIND_WRITE;
         result.slot_address    = addr;
         result.erase_first     = erase;
         result.record_sequence = wseq_inc;
         result.record_checksum = sum;
         result.found_slot      = 4'(next_slot_ff);
         result.next_write_slot = 4'(slot_next);
      end else begin
         result.result_kind     = KIND_SCAN;
         result.found_valid     = best_valid_in;
         result.next_write_slot = it.req_type == REQ_SCAN_INIT ? 4'(reload_slot)
                                                                : 4'(next_slot_ff);
         if (best_valid_in) begin
            result.record_sequence = best_seq_in;
            result.found_slot      = 4'(best_slot_in);
            result.found_seconds   = best_secs_in;
            result.found_word_a    = best_word_in;
            result.found_half_b    = best_half_in;
         end
      end
   end

endmodule

// ----- rtl/frw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_checker
// Port-level checks on the result channel of the wear leveler.
// ----------------------------------------------------------------------------
module frw_checker import frw_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input frw_rsp_item_type rsp_payload
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Result item changed or dropped while stalled.");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == KIND_WRITE |->
         !rsp_payload.found_valid && rsp_payload.found_seconds == 32'd0 &&
         rsp_payload.found_word_a == 32'd0 && rsp_payload.found_half_b == 16'd0)
      else $error("Write command carries scan fields.");

   a_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == KIND_SCAN |->
         rsp_payload.slot_address == '0 && !rsp_payload.erase_first &&
         rsp_payload.record_checksum == 16'd0 &&
         (rsp_payload.found_valid ||
          (rsp_payload.record_sequence == 32'd0 && rsp_payload.found_slot == 4'd0)))
      else $error("Scan outcome carries write fields or stale record.");

endmodule

bind flash_record_ring_wear_leveler frw_checker u_frw_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

// ----- bench/tb_flash_record_ring_wear_leveler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_record_ring_wear_leveler
// Self-checking bench for the flash record ring: write commands and scans.
// A short table of requests opens the run. Some rows carry a hand-written
// result, and all other rows are checked against a cycle-free model of the
// ring. Random requests follow in four phases of sender and receiver
// stalls, each phase with its own ring base address. Scans are mostly
// well-formed runs of sixteen headers, mixed with writes, near-miss headers
// and noise.
// ----------------------------------------------------------------------------
module tb_flash_record_ring_wear_leveler;
   import frw_pkg::*;

   localparam int unsigned SLOT_COUNT        = 16;
   localparam int unsigned SLOT_STRIDE_BYTES = 1024;
   localparam int unsigned SECTOR_BYTES      = 4096;
   localparam logic [1:0]  REQ_UNUSED        = 2'd3;
   localparam int          PHASE_ITEMS       = 350;
   localparam int          SETTLE_CYCLES     = 4;

   typedef struct {
      frw_req_item_type item;
      bit               pinned;
      frw_rsp_item_type want;
   } plan_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ADDR_W-1:0] csr_wdata;

   frw_req_if req_bus ();
   frw_rsp_if rsp_bus ();

   flash_record_ring_wear_leveler #(
      .SLOT_COUNT(SLOT_COUNT),
      .SLOT_STRIDE_BYTES(SLOT_STRIDE_BYTES),
      .SECTOR_BYTES(SECTOR_BYTES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // Model state of the ring.
   logic [ADDR_W-1:0] ring_base = BASE_RESET;
   logic [3:0]        wr_slot = '0;
   logic [31:0]       wr_seq = '0;
   logic [3:0]        scan_pos = '0;
   logic [31:0]       best_seq = '0;
   logic              best_valid = 1'b0;
   logic [3:0]        best_slot = '0;
   logic [31:0]       best_seconds = '0;
   logic [31:0]       best_word_a = '0;
   logic [15:0]       best_half_b = '0;

   frw_rsp_item_type ring_results_q[$];
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   bit               row_pinned = 1'b0;
   frw_rsp_item_type row_expect = '0;

   int               gen_scan_pos = 0;
   int               scan_good_pct = 0;
   logic [1:0]       scan_kind = REQ_SCAN_READ;

   plan_row_type     opening_plan[$];

   function automatic logic [15:0] payload_byte_sum(input logic [31:0] secs,
                                                    input logic [31:0] word_a,
                                                    input logic [15:0] half_b);
      logic [15:0] sum;
      sum = '0;
      for (int i = 0; i < 4; i++) begin
         sum = sum + 16'(secs[8*i +: 8]) + 16'(word_a[8*i +: 8]);
      end
      return sum + 16'(half_b[7:0]) + 16'(half_b[15:8]);
   endfunction

   function automatic bit ring_step(input frw_req_item_type it,
                                    output frw_rsp_item_type r);
      logic [ADDR_W-1:0] addr;
      logic [15:0]       sum;
      r = '0;
      sum = payload_byte_sum(it.payload_seconds, it.payload_word_a, it.payload_half_b);
      if (it.req_type == REQ_UNUSED) begin
         return 1'b0;
      end
      if (it.req_type == REQ_WRITE) begin
         addr = ring_base + ADDR_W'(int'(wr_slot) * SLOT_STRIDE_BYTES);
         wr_seq = wr_seq + 32'd1;
         r.result_kind = KIND_WRITE;
         r.slot_address = addr;
         r.erase_first = (addr % SECTOR_BYTES) == 0;
         r.record_sequence = wr_seq;
         r.record_checksum = sum;
         r.found_slot = wr_slot;
         wr_slot = 4'((int'(wr_slot) + 1) % SLOT_COUNT);
         r.next_write_slot = wr_slot;
         return 1'b1;
      end
      if (scan_pos == 0) begin
         best_seq = '0;
         best_valid = 1'b0;
         best_slot = '0;
         best_seconds = '0;
         best_word_a = '0;
         best_half_b = '0;
      end
      if (!it.header_read_error && it.header_magic == HEADER_MAGIC &&
          it.header_checksum == sum && it.header_sequence > best_seq) begin
         best_seq = it.header_sequence;
         best_valid = 1'b1;
         best_slot = scan_pos;
         best_seconds = it.payload_seconds;
         best_word_a = it.payload_word_a;
         best_half_b = it.payload_half_b;
      end
      if (int'(scan_pos) + 1 < SLOT_COUNT) begin
         scan_pos = scan_pos + 4'd1;
         return 1'b0;
      end
      scan_pos = '0;
      if (it.req_type == REQ_SCAN_INIT) begin
         wr_slot = best_valid ? 4'((int'(best_slot) + 1) % SLOT_COUNT) : 4'd0;
         wr_seq = best_valid ? best_seq : 32'd0;
      end
      r.result_kind = KIND_SCAN;
      r.next_write_slot = wr_slot;
      if (best_valid) begin
         r.record_sequence = best_seq;
         r.found_valid = 1'b1;
         r.found_slot = best_slot;
         r.found_seconds = best_seconds;
         r.found_word_a = best_word_a;
         r.found_half_b = best_half_b;
      end
      return 1'b1;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      frw_rsp_item_type predicted;
      frw_rsp_item_type want;
      frw_rsp_item_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (ring_results_q.size() == 0) begin
               $error("result item with no expectation pending");
               mismatch_count++;
            end else begin
               want = ring_results_q.pop_front();
               compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
               compare_field("slot_address", 32'(want.slot_address), 32'(got.slot_address));
               compare_field("erase_first", 32'(want.erase_first), 32'(got.erase_first));
               compare_field("record_sequence", want.record_sequence, got.record_sequence);
               compare_field("record_checksum", 32'(want.record_checksum),
                             32'(got.record_checksum));
               compare_field("found_valid", 32'(want.found_valid), 32'(got.found_valid));
               compare_field("found_slot", 32'(want.found_slot), 32'(got.found_slot));
               compare_field("next_write_slot", 32'(want.next_write_slot),
                             32'(got.next_write_slot));
               compare_field("found_seconds", want.found_seconds, got.found_seconds);
               compare_field("found_word_a", want.found_word_a, got.found_word_a);
               compare_field("found_half_b", 32'(want.found_half_b), 32'(got.found_half_b));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (ring_step(req_bus.payload, predicted)) begin
               ring_results_q.push_back(row_pinned ? row_expect : predicted);
            end
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic frw_req_item_type random_request();
      frw_req_item_type it;
      int roll;
      bit good;
      bit near_miss;
      roll = $urandom_range(0, 99);
      it.payload_seconds = pick_word();
      it.payload_word_a = pick_word();
      it.payload_half_b = 16'(pick_word());
      it.header_read_error = 1'($urandom_range(0, 1));
      it.header_magic = 16'($urandom);
      it.header_sequence = $urandom;
      it.header_checksum = 16'($urandom);
      if (roll < 4) begin
         it.req_type = REQ_UNUSED;
      end else if (roll < 8) begin
         it.req_type = 2'($urandom_range(0, 3));
      end else if (roll < 35) begin
         it.req_type = REQ_WRITE;
      end else begin
         if (gen_scan_pos == 0) begin
            case ($urandom_range(0, 2))
               0: scan_good_pct = 0;
               1: scan_good_pct = 40;
               default: scan_good_pct = 85;
            endcase
            scan_kind = $urandom_range(0, 1) ? REQ_SCAN_INIT : REQ_SCAN_READ;
         end
         if ($urandom_range(0, 9) == 0) begin
            it.req_type = (scan_kind == REQ_SCAN_INIT) ? REQ_SCAN_READ : REQ_SCAN_INIT;
         end else begin
            it.req_type = scan_kind;
         end
         good = $urandom_range(0, 99) < scan_good_pct;
         near_miss = !good && $urandom_range(0, 1);
         if (good || near_miss) begin
            it.header_read_error = 1'b0;
            it.header_magic = HEADER_MAGIC;
            it.header_checksum = payload_byte_sum(it.payload_seconds, it.payload_word_a,
                                                  it.payload_half_b);
            case ($urandom_range(0, 3))
               0: it.header_sequence = $urandom;
               1: it.header_sequence = $urandom_range(1, 64);
               2: it.header_sequence = 32'hFFFF_FFFF - $urandom_range(0, 3);
               default: it.header_sequence = 32'h0;
            endcase
         end
         if (near_miss) begin
            case ($urandom_range(0, 2))
               0: it.header_read_error = 1'b1;
               1: it.header_magic ^= 16'(1 << $urandom_range(0, 15));
               default: it.header_checksum ^= 16'(1 << $urandom_range(0, 15));
            endcase
         end
      end
      if (it.req_type == REQ_SCAN_INIT || it.req_type == REQ_SCAN_READ) begin
         gen_scan_pos = (gen_scan_pos + 1) % SLOT_COUNT;
      end
      return it;
   endfunction

   task automatic offer_request(input frw_req_item_type it, input bit pinned,
                                input frw_rsp_item_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.payload = it;
      row_pinned = pinned;
      row_expect = want;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (ring_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_ring_base(input logic [ADDR_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      ring_base = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = $urandom_range(0, 99) >= stall_pct;
      end
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int sent;
      logic [ADDR_W-1:0] phase_base;
      frw_req_item_type item;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;

      opening_plan.push_back('{frw_req_item_type'{REQ_WRITE, 1'b0, 16'h0, 32'h0, 16'h0,
                                                  32'h0, 32'h0, 16'h0}, 1'b1,
                               frw_rsp_item_type'{KIND_WRITE, 24'h010000, 1'b1, 32'd1,
                                                  16'h0, 1'b0, 4'd0, 4'd1, 32'h0, 32'h0,
                                                  16'h0}});
      opening_plan.push_back('{frw_req_item_type'{REQ_WRITE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
                                                  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                  16'hFFFF}, 1'b1,
                               frw_rsp_item_type'{KIND_WRITE, 24'h010400, 1'b0, 32'd2,
                                                  16'h09F6, 1'b0, 4'd1, 4'd2, 32'h0, 32'h0,
                                                  16'h0}});
      opening_plan.push_back('{frw_req_item_type'{REQ_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
                                                  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                  16'hFFFF}, 1'b0, '0});
      // The scan below holds a read error, a bad magic word, a bad checksum,
      // a zero sequence and a stale sequence, with a write in the middle.
      opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_READ, 1'b1, HEADER_MAGIC, 32'd9,
                                                  16'h0, 32'h0, 32'h0, 16'h0}, 1'b0, '0});
      opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_READ, 1'b0, 16'hA55B, 32'd9,
                                                  16'h0, 32'h0, 32'h0, 16'h0}, 1'b0, '0});
      opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_READ, 1'b0, HEADER_MAGIC, 32'd9,
                                                  16'h1, 32'h0, 32'h0, 16'h0}, 1'b0, '0});
      opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_READ, 1'b0, HEADER_MAGIC, 32'd0,
                                                  16'h0, 32'h0, 32'h0, 16'h0}, 1'b0, '0});
      opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_READ, 1'b0, HEADER_MAGIC, 32'd5,
                                                  16'h000A, 32'h0102_0304, 32'h0, 16'h0},
                               1'b0, '0});
      opening_plan.push_back('{frw_req_item_type'{REQ_WRITE, 1'b0, 16'h0, 32'h0, 16'h0,
                                                  32'h0, 32'h0, 16'h0}, 1'b1,
                               frw_rsp_item_type'{KIND_WRITE, 24'h010800, 1'b0, 32'd3,
                                                  16'h0, 1'b0, 4'd2, 4'd3, 32'h0, 32'h0,
                                                  16'h0}});
      opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_READ, 1'b0, HEADER_MAGIC, 32'd3,
                                                  16'h0003, 32'h0, 32'h0, 16'h0003},
                               1'b0, '0});
      opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_READ, 1'b0, HEADER_MAGIC,
                                                  32'hFFFF_FFFF, 16'h09F6, 32'hFFFF_FFFF,
                                                  32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0});
      for (int i = 7; i < 15; i++) begin
         opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_READ, 1'b0, 16'hFFFF,
                                                     32'hFFFF_FFFF, 16'hFFFF, 32'h0, 32'h0,
                                                     16'h0}, 1'b0, '0});
      end
      // A closing header of the init kind reloads the ring from a read scan.
      opening_plan.push_back('{frw_req_item_type'{REQ_SCAN_INIT, 1'b0, HEADER_MAGIC, 32'd5,
                                                  16'h000A, 32'h0102_0304, 32'h0, 16'h0},
                               1'b1,
                               frw_rsp_item_type'{KIND_SCAN, 24'h0, 1'b0, 32'hFFFF_FFFF,
                                                  16'h0, 1'b1, 4'd6, 4'd7, 32'hFFFF_FFFF,
                                                  32'hFFFF_FFFF, 16'hFFFF}});
      // The reloaded counter wraps to zero on the next write.
      opening_plan.push_back('{frw_req_item_type'{REQ_WRITE, 1'b0, 16'h0, 32'h0, 16'h0,
                                                  32'h0, 32'h0, 16'h0}, 1'b1,
                               frw_rsp_item_type'{KIND_WRITE, 24'h011C00, 1'b0, 32'd0,
                                                  16'h0, 1'b0, 4'd7, 4'd8, 32'h0, 32'h0,
                                                  16'h0}});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (opening_plan[i]) begin
         offer_request(opening_plan[i].item, opening_plan[i].pinned, opening_plan[i].want);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: phase_base = 24'hFFFFFF;
            1: phase_base = 24'h000000;
            2: phase_base = ADDR_W'($urandom);
            default: phase_base = 24'hFFF000;
         endcase
         write_ring_base(phase_base);
         send_idle_pct = (phase == 1) ? 67 : (phase == 3) ? 37 : 0;
         stall_pct = (phase == 2) ? 67 : (phase == 3) ? 37 : 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            item = random_request();
            if (item.req_type != REQ_UNUSED) begin
               sent++;
            end
            offer_request(item, 1'b0, '0);
            if (sent % 150 == 149) begin
               drain_results();
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && ring_results_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
